// File: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stream find-and-replace block
// Payload structs of both channels, the configuration image and the burst
// descriptor that travels from the front to the back.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int BYTE_W          = 8;
	localparam int REG_W           = 64;
	localparam int LEN_W           = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int DEF_MAX_PATTERN = 8;
	localparam int DEF_MAX_REPLACE = 8;
	localparam int SLOT_MAX        = 8;
	localparam int LIT_W           = 4;
	localparam int TOT_W           = 5;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PATTERN_LENGTH = 2'd1,
		REG_REPLACE_BYTES  = 2'd2,
		REG_REPLACE_LENGTH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_content;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              burst_last;
		logic              stream_end;
	} out_item_t;

	typedef struct packed {
		logic [REG_W-1:0] pattern_bytes;
		logic [LEN_W-1:0] pattern_length;
		logic [REG_W-1:0] replace_bytes;
		logic [LEN_W-1:0] replace_length;
	} cfg_t;

	typedef struct packed {
		logic [SLOT_MAX-1:0][BYTE_W-1:0] bytes;
		logic [LIT_W-1:0]                lit_count;
		logic [TOT_W-1:0]                total;
		logic                            eoc;
		logic                            marker;
	} burst_t;

endpackage

// File: rtl/core/sfr_stream_if.sv
// ----------------------------------------------------------------------------
// sfr_stream_if: valid/ready stream channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue: small FIFO between the front and the back
// Register-based, with simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module sfr_queue #(
	parameter type T     = logic,
	parameter int  DEPTH = sfr_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     push_data,
	output logic full,
	input  logic pop,
	output T     pop_data,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	T                slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == NW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: byte intake and match classification
// Keeps the held pattern prefix, decides per byte which bytes are released
// and whether a match fires, and hands the result to the queue as a burst.
// ----------------------------------------------------------------------------
module sfr_front #(
	parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
	parameter int MAX_REPLACE = sfr_pkg::DEF_MAX_REPLACE
) (
	input  logic            clk,
	input  logic            arst_n,
	sfr_stream_if.sink      in_stream,
	input  sfr_pkg::cfg_t   cfg,
	input  logic            pattern_write,
	input  logic            queue_full,
	output logic            push,
	output sfr_pkg::burst_t burst
);
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int RW = $clog2(MAX_REPLACE + 2);

	logic [sfr_pkg::BYTE_W-1:0] held_q [MAX_PATTERN];
	logic [CW-1:0]              held_count_q;
	logic                       stale_q;

	logic [sfr_pkg::BYTE_W-1:0] cand   [MAX_PATTERN];
	logic [sfr_pkg::BYTE_W-1:0] pat    [MAX_PATTERN];
	logic [sfr_pkg::BYTE_W-1:0] held_d [MAX_PATTERN];
	logic [CW-1:0]              plen;
	logic [CW-1:0]              clen;
	logic [CW-1:0]              start;
	logic [CW-1:0]              len;
	logic [CW-1:0]              lit;
	logic [RW-1:0]              rlen;
	logic [MAX_PATTERN-1:0]     ok;
	logic [sfr_pkg::TOT_W-1:0]  total_raw;
	logic                       match;
	logic                       flush;
	logic                       repl;
	logic                       eoc;
	logic                       accept;

	assign in_stream.ready = !queue_full;
	assign accept          = in_stream.valid && in_stream.ready;
	assign eoc             = in_stream.data.end_of_content;

	always_comb begin
		if (cfg.pattern_length == '0) begin
			plen = CW'(1);
		end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
			plen = CW'(MAX_PATTERN);
		end else begin
			plen = CW'(cfg.pattern_length);
		end
		if (int'(cfg.replace_length) > MAX_REPLACE) begin
			rlen = RW'(MAX_REPLACE);
		end else begin
			rlen = RW'(cfg.replace_length);
		end
	end

	always_comb begin
		clen = held_count_q + 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pat[i] = cfg.pattern_bytes[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
			if (CW'(i) < held_count_q) begin
				cand[i] = held_q[i];
			end else if (CW'(i) == held_count_q) begin
				cand[i] = in_stream.data.in_byte;
			end else begin
				cand[i] = '0;
			end
		end
	end

	// A start position is good when the rest of the candidate is a pattern prefix.
	always_comb begin
		for (int s = 0; s < MAX_PATTERN; s++) begin
			ok[s] = (CW'(s) < clen) && ((clen - CW'(s)) <= plen);
			for (int i = 0; i < MAX_PATTERN - s; i++) begin
				if ((CW'(s + i) < clen) && (cand[s + i] != pat[i])) begin
					ok[s] = 1'b0;
				end
			end
		end
		start = clen;
		for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
			if (ok[s]) begin
				start = CW'(s);
			end
		end
		len   = clen - start;
		match = (start != clen) && (len == plen);
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			held_d[i] = '0;
			for (int s = 0; s < MAX_PATTERN - s + s && s < MAX_PATTERN - i; s++) begin
				if (start == CW'(s)) begin
					held_d[i] = cand[s + i];
				end
			end
		end
	end

	always_comb begin
		flush     = stale_q || eoc;
		repl      = !stale_q && match;
		lit       = (stale_q || (eoc && !match)) ? clen : start;
		total_raw = sfr_pkg::TOT_W'(lit) + (repl ? sfr_pkg::TOT_W'(rlen) : '0);

		burst.bytes = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			burst.bytes[i] = cand[i];
		end
		burst.lit_count = sfr_pkg::LIT_W'(lit);
		burst.eoc       = eoc;
		burst.marker    = (total_raw == '0) && eoc;
		burst.total     = burst.marker ? sfr_pkg::TOT_W'(1) : total_raw;

		push = accept && ((total_raw != '0) || eoc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			stale_q      <= 1'b0;
		end else if (accept) begin
			stale_q      <= 1'b0;
			held_count_q <= (flush || match) ? '0 : len;
		end else if (pattern_write && (held_count_q != '0)) begin
			stale_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				held_q[i] <= held_d[i];
			end
		end
	end

endmodule

// File: rtl/core/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: burst playout
// Takes one burst from the queue at a time and sends its released bytes,
// then the replacement text, one result per transaction.
// ----------------------------------------------------------------------------
module sfr_back #(
	parameter int MAX_REPLACE = sfr_pkg::DEF_MAX_REPLACE
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sfr_pkg::cfg_t   cfg,
	input  logic            queue_empty,
	input  sfr_pkg::burst_t head,
	output logic            pop,
	sfr_stream_if.source    out_stream
);
	sfr_pkg::burst_t            cur_q;
	logic                       cur_valid_q;
	logic [sfr_pkg::TOT_W-1:0]  idx_q;
	logic [sfr_pkg::TOT_W-1:0]  rel;
	logic [sfr_pkg::BYTE_W-1:0] obyte;
	logic                       last;
	logic                       advance;
	logic                       load;

	assign last    = (idx_q == cur_q.total - 1'b1);
	assign advance = out_stream.valid && out_stream.ready;
	assign load    = !cur_valid_q || (advance && last);
	assign pop     = load && !queue_empty;
	assign rel     = idx_q - sfr_pkg::TOT_W'(cur_q.lit_count);

	always_comb begin
		obyte = '0;
		if (!cur_q.marker) begin
			if (idx_q < sfr_pkg::TOT_W'(cur_q.lit_count)) begin
				for (int i = 0; i < sfr_pkg::SLOT_MAX; i++) begin
					if (idx_q == sfr_pkg::TOT_W'(i)) begin
						obyte = cur_q.bytes[i];
					end
				end
			end else begin
				for (int i = 0; i < MAX_REPLACE; i++) begin
					if (rel == sfr_pkg::TOT_W'(i)) begin
						obyte = cfg.replace_bytes[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
					end
				end
			end
		end
	end

	assign out_stream.valid           = cur_valid_q;
	assign out_stream.data.out_byte   = obyte;
	assign out_stream.data.byte_valid = !cur_q.marker;
	assign out_stream.data.burst_last = last;
	assign out_stream.data.stream_end = last && cur_q.eoc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			cur_valid_q <= !queue_empty;
			idx_q       <= '0;
		end else if (advance) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

endmodule

// File: rtl/core/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace: streaming find-and-replace on a byte stream
// Replaces every leftmost, non-overlapping occurrence of the configured
// pattern with the configured replacement text.
// ----------------------------------------------------------------------------
// Channel      Direction  Transaction payload
// in_stream    sink       in_byte, end_of_content
// out_stream   source     out_byte, byte_valid, burst_last, stream_end
// cfg_*        write      cfg_index selects the register, cfg_data its value
//
// The front takes one byte per cycle, while the queue is not full, and
// classifies it in that cycle. Each byte yields a burst of zero to eight
// results; the back sends one result per cycle while the output is ready.
// A four-entry queue between the two lets the input run while a burst plays.
// Reset clears the held prefix, the queue and the output; no clearing pass.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
	parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
	parameter int MAX_REPLACE = sfr_pkg::DEF_MAX_REPLACE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sfr_stream_if.sink                    in_stream,
	sfr_stream_if.source                  out_stream,
	input  logic                          cfg_write_en,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::REG_W-1:0]     cfg_data
);
	sfr_pkg::cfg_t   cfg_q;
	sfr_pkg::burst_t push_burst;
	sfr_pkg::burst_t head_burst;
	logic            pattern_write;
	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_empty;

	assign pattern_write = cfg_write_en &&
		((cfg_index == sfr_pkg::REG_PATTERN_BYTES) ||
		 (cfg_index == sfr_pkg::REG_PATTERN_LENGTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes  <= '0;
			cfg_q.pattern_length <= sfr_pkg::LEN_W'(1);
			cfg_q.replace_bytes  <= '0;
			cfg_q.replace_length <= '0;
		end else if (cfg_write_en) begin
			case (sfr_pkg::cfg_reg_t'(cfg_index))
				sfr_pkg::REG_PATTERN_BYTES: begin
					cfg_q.pattern_bytes <= cfg_data;
				end
				sfr_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[sfr_pkg::LEN_W-1:0];
				end
				sfr_pkg::REG_REPLACE_BYTES: begin
					cfg_q.replace_bytes <= cfg_data;
				end
				sfr_pkg::REG_REPLACE_LENGTH: begin
					cfg_q.replace_length <= cfg_data[sfr_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sfr_front #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_REPLACE (MAX_REPLACE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_stream     (in_stream),
		.cfg           (cfg_q),
		.pattern_write (pattern_write),
		.queue_full    (queue_full),
		.push          (push),
		.burst         (push_burst)
	);

	sfr_queue #(
		.T     (sfr_pkg::burst_t),
		.DEPTH (sfr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_burst),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (head_burst),
		.empty     (queue_empty)
	);

	sfr_back #(
		.MAX_REPLACE (MAX_REPLACE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_empty (queue_empty),
		.head        (head_burst),
		.pop         (pop),
		.out_stream  (out_stream)
	);

endmodule
